### design/flow_directory_table_unit_assert.svh
// Assertion macros for the flow directory table unit.
// Depends on nothing; included by the top level.
`ifndef FLOW_DIRECTORY_TABLE_UNIT_ASSERT_SVH
`define FLOW_DIRECTORY_TABLE_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define FDT_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("fdt check failed");

// Antecedent implies consequent in the next cycle.
`define FDT_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("fdt check failed");

`endif

### design/fdt_pkg.sv
// Shared constants, codes and types for the flow directory table unit.
// No dependencies; used by fdt_cmp and flow_directory_table_unit.
package fdt_pkg;

    localparam int PEERS        = 16;
    localparam int OUT_PER_PEER = 8;
    localparam int IN_PER_PEER  = 8;

    localparam int PEER_W = 4;
    localparam int ID_W   = 16;
    localparam int SLOT_W = 16;
    localparam int ENT_W  = ID_W + SLOT_W;
    localparam int IDX_W  = 3;

    localparam int OUT_DEPTH = PEERS * OUT_PER_PEER;
    localparam int IN_DEPTH  = PEERS * IN_PER_PEER;
    localparam int OUT_AW    = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int IN_AW     = (IN_DEPTH > 1) ? $clog2(IN_DEPTH) : 1;
    localparam int MAX_SEG   = (OUT_PER_PEER > IN_PER_PEER) ? OUT_PER_PEER : IN_PER_PEER;
    localparam int SEG_W     = (MAX_SEG > 1) ? $clog2(MAX_SEG) : 1;

    localparam logic [1:0] CMD_FIND   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_DUP       = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    typedef struct packed {
        logic hit;
        logic free;
    } cmp_res_t;

endpackage

### design/flow_directory_table_unit.sv
// Flow directory table: per-peer segments mapping flow id to slot, scanned
// one entry per cycle through a shared compare unit. Depends on fdt_pkg,
// fdt_ram, fdt_cmp and flow_directory_table_unit_assert.svh.
// Sequence from accept: scan of the segment (size W), then drain, commit, finish.
// Out-of-range peer or unused command: straight to the finish state, no scan.
// A new command is stalled until the result word of the last one is loaded.
// Reset: all entry valid flags clear at once; no clearing pass.
`include "flow_directory_table_unit_assert.svh"

module flow_directory_table_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [1:0]                   command,
    input  logic                         direction,
    input  logic [fdt_pkg::PEER_W-1:0]   peer,
    input  logic [fdt_pkg::ID_W-1:0]     flow_id,
    input  logic [fdt_pkg::SLOT_W-1:0]   flow_slot,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic [1:0]                   status,
    output logic [fdt_pkg::SLOT_W-1:0]   found_slot,
    output logic [fdt_pkg::IDX_W-1:0]    entry_index
);

    localparam int OAW   = fdt_pkg::OUT_AW;
    localparam int IAW   = fdt_pkg::IN_AW;
    localparam int SW    = fdt_pkg::SEG_W;
    localparam logic [SW-1:0] OUT_LAST = SW'(fdt_pkg::OUT_PER_PEER - 1);
    localparam logic [SW-1:0] IN_LAST  = SW'(fdt_pkg::IN_PER_PEER - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    // control
    logic [SW-1:0] cnt_reg;
    logic          chk_valid_reg;
    logic          hit_reg;
    logic          free_seen_reg;
    logic          res_valid_reg;
    logic          out_vbit_reg [fdt_pkg::OUT_DEPTH];
    logic          in_vbit_reg  [fdt_pkg::IN_DEPTH];

    // payload
    logic [1:0]                 cmd_reg;
    logic                       dir_reg;
    logic [fdt_pkg::ID_W-1:0]   id_reg;
    logic [fdt_pkg::SLOT_W-1:0] slot_reg;
    logic [OAW-1:0]             out_base_reg;
    logic [IAW-1:0]             in_base_reg;
    logic [SW-1:0]              chk_idx_reg;
    logic                       chk_vbit_reg;
    logic [SW-1:0]              hit_idx_reg;
    logic [fdt_pkg::SLOT_W-1:0] hit_slot_reg;
    logic [SW-1:0]              free_idx_reg;
    logic [1:0]                 pend_status_reg;
    logic [fdt_pkg::SLOT_W-1:0] pend_slot_reg;
    logic [fdt_pkg::IDX_W-1:0]  pend_index_reg;
    logic [1:0]                 res_status_reg;
    logic [fdt_pkg::SLOT_W-1:0] res_slot_reg;
    logic [fdt_pkg::IDX_W-1:0]  res_index_reg;

    logic                       accept;
    logic                       peer_ok;
    logic                       cmd_ok;
    logic                       scan_last;
    logic                       res_load;
    logic [OAW-1:0]             out_raddr;
    logic [IAW-1:0]             in_raddr;
    logic [fdt_pkg::ENT_W-1:0]  out_rdata;
    logic [fdt_pkg::ENT_W-1:0]  in_rdata;
    logic [fdt_pkg::ENT_W-1:0]  chk_entry;
    fdt_pkg::cmp_res_t          cmp_res;
    logic [SW-1:0]              tgt_off;
    logic [OAW-1:0]             out_waddr;
    logic [IAW-1:0]             in_waddr;
    logic                       tgt_vbit;
    logic                       ins_ok;
    logic                       ers_ok;
    logic                       out_we;
    logic                       in_we;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign peer_ok   = (32'(peer) < 32'(fdt_pkg::PEERS));
    assign cmd_ok    = (command == fdt_pkg::CMD_FIND) || (command == fdt_pkg::CMD_INSERT)
                    || (command == fdt_pkg::CMD_ERASE);
    assign scan_last = (cnt_reg == (dir_reg ? IN_LAST : OUT_LAST));
    assign res_load  = (state_reg == ST_FINISH) && (!res_valid_reg || !res_stall);

    assign out_raddr = out_base_reg + OAW'(cnt_reg);
    assign in_raddr  = in_base_reg + IAW'(cnt_reg);
    assign chk_entry = dir_reg ? in_rdata : out_rdata;

    // commit target: free entry on insert, matched entry on erase
    assign tgt_off   = (cmd_reg == fdt_pkg::CMD_INSERT) ? free_idx_reg : hit_idx_reg;
    assign out_waddr = out_base_reg + OAW'(tgt_off);
    assign in_waddr  = in_base_reg + IAW'(tgt_off);
    assign tgt_vbit  = dir_reg ? in_vbit_reg[in_waddr] : out_vbit_reg[out_waddr];
    assign ins_ok    = (state_reg == ST_COMMIT) && (cmd_reg == fdt_pkg::CMD_INSERT)
                    && !hit_reg && free_seen_reg;
    assign ers_ok    = (state_reg == ST_COMMIT) && (cmd_reg == fdt_pkg::CMD_ERASE) && hit_reg;
    assign out_we    = ins_ok && !dir_reg;
    assign in_we     = ins_ok && dir_reg;

    fdt_ram #(
        .DEPTH (fdt_pkg::OUT_DEPTH),
        .WIDTH (fdt_pkg::ENT_W)
    ) u_out_ram (
        .clk   (clk),
        .we    (out_we),
        .waddr (out_waddr),
        .wdata ({id_reg, slot_reg}),
        .raddr (out_raddr),
        .rdata (out_rdata)
    );

    fdt_ram #(
        .DEPTH (fdt_pkg::IN_DEPTH),
        .WIDTH (fdt_pkg::ENT_W)
    ) u_in_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata ({id_reg, slot_reg}),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    fdt_cmp u_cmp (
        .command     (cmd_reg),
        .key_id      (id_reg),
        .key_slot    (slot_reg),
        .entry       (chk_entry),
        .entry_valid (chk_vbit_reg),
        .res         (cmp_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (peer_ok && cmd_ok) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:  state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (res_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            free_seen_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < fdt_pkg::OUT_DEPTH; i++)
            begin
                out_vbit_reg[i] <= 1'b0;
            end
            for (int i = 0; i < fdt_pkg::IN_DEPTH; i++)
            begin
                in_vbit_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= (state_reg == ST_SCAN);

            if (accept)
            begin
                cnt_reg       <= '0;
                hit_reg       <= 1'b0;
                free_seen_reg <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                cnt_reg <= cnt_reg + SW'(1);
            end

            // keep the first hit and the first free entry of the scan
            if (chk_valid_reg && cmp_res.hit)
            begin
                hit_reg <= 1'b1;
            end
            if (chk_valid_reg && cmp_res.free)
            begin
                free_seen_reg <= 1'b1;
            end

            if (ins_ok && !dir_reg)
            begin
                out_vbit_reg[out_waddr] <= 1'b1;
            end
            if (ins_ok && dir_reg)
            begin
                in_vbit_reg[in_waddr] <= 1'b1;
            end
            if (ers_ok && !dir_reg)
            begin
                out_vbit_reg[out_waddr] <= 1'b0;
            end
            if (ers_ok && dir_reg)
            begin
                in_vbit_reg[in_waddr] <= 1'b0;
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg         <= command;
            dir_reg         <= direction;
            id_reg          <= flow_id;
            slot_reg        <= flow_slot;
            out_base_reg    <= OAW'(32'(peer) * 32'(fdt_pkg::OUT_PER_PEER));
            in_base_reg     <= IAW'(32'(peer) * 32'(fdt_pkg::IN_PER_PEER));
            pend_status_reg <= fdt_pkg::STAT_NOT_FOUND;
            pend_slot_reg   <= '0;
            pend_index_reg  <= '0;
        end

        if (state_reg == ST_SCAN)
        begin
            chk_idx_reg  <= cnt_reg;
            chk_vbit_reg <= dir_reg ? in_vbit_reg[in_raddr] : out_vbit_reg[out_raddr];
        end

        if (chk_valid_reg && cmp_res.hit && !hit_reg)
        begin
            hit_idx_reg  <= chk_idx_reg;
            hit_slot_reg <= chk_entry[fdt_pkg::SLOT_W-1:0];
        end
        if (chk_valid_reg && cmp_res.free && !free_seen_reg)
        begin
            free_idx_reg <= chk_idx_reg;
        end

        if (state_reg == ST_COMMIT)
        begin
            case (cmd_reg)
                fdt_pkg::CMD_FIND:
                begin
                    if (hit_reg)
                    begin
                        pend_status_reg <= fdt_pkg::STAT_OK;
                        pend_slot_reg   <= hit_slot_reg;
                    end
                end
                fdt_pkg::CMD_INSERT:
                begin
                    if (hit_reg)
                    begin
                        pend_status_reg <= fdt_pkg::STAT_DUP;
                    end
                    else if (!free_seen_reg)
                    begin
                        pend_status_reg <= fdt_pkg::STAT_FULL;
                    end
                    else
                    begin
                        pend_status_reg <= fdt_pkg::STAT_OK;
                        pend_index_reg  <= fdt_pkg::IDX_W'(free_idx_reg);
                    end
                end
                fdt_pkg::CMD_ERASE:
                begin
                    if (hit_reg)
                    begin
                        pend_status_reg <= fdt_pkg::STAT_OK;
                        pend_index_reg  <= fdt_pkg::IDX_W'(hit_idx_reg);
                    end
                end
                default:
                begin
                    pend_status_reg <= fdt_pkg::STAT_NOT_FOUND;
                end
            endcase
        end

        if (res_load)
        begin
            res_status_reg <= pend_status_reg;
            res_slot_reg   <= pend_slot_reg;
            res_index_reg  <= pend_index_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign status      = res_status_reg;
    assign found_slot  = res_slot_reg;
    assign entry_index = res_index_reg;

    `FDT_ASSERT_SAME(a_erase_hits_live, clk, rst_n, ers_ok, tgt_vbit)
    `FDT_ASSERT_SAME(a_insert_into_free, clk, rst_n, ins_ok, !tgt_vbit)
    `FDT_ASSERT_NEXT(a_word_from_finish, clk, rst_n, res_load, res_valid && state_reg == ST_IDLE)

endmodule

### design/fdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the id and slot of directory entries.
module fdt_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/fdt_cmp.sv
// Entry compare unit: matches one directory entry against the search key.
// Depends on fdt_pkg.
module fdt_cmp (
    input  logic [1:0]                 command,
    input  logic [fdt_pkg::ID_W-1:0]   key_id,
    input  logic [fdt_pkg::SLOT_W-1:0] key_slot,
    input  logic [fdt_pkg::ENT_W-1:0]  entry,
    input  logic                       entry_valid,
    output fdt_pkg::cmp_res_t          res
);

    logic [fdt_pkg::ID_W-1:0]   ent_id;
    logic [fdt_pkg::SLOT_W-1:0] ent_slot;

    assign ent_id   = entry[fdt_pkg::ENT_W-1:fdt_pkg::SLOT_W];
    assign ent_slot = entry[fdt_pkg::SLOT_W-1:0];

    always_comb
    begin
        res.free = !entry_valid;
        // erase keys on slot, find and insert key on id
        if (command == fdt_pkg::CMD_ERASE)
        begin
            res.hit = entry_valid && (ent_slot == key_slot);
        end
        else
        begin
            res.hit = entry_valid && (ent_id == key_id);
        end
    end

endmodule
